// File: design/frm_pkg.sv
// Shared constants, codes and interface types for the windowed frame rate meter.
package frm_pkg;

  localparam int TIME_BITS     = 32;
  localparam int WIN_MAX       = 64;
  localparam int SLOT_BITS     = $clog2(WIN_MAX);
  localparam int COUNT_BITS    = $clog2(WIN_MAX + 1);
  localparam int SUM_BITS      = TIME_BITS + SLOT_BITS;
  localparam int RATE_BITS     = 30;
  localparam int STEP_BITS     = $clog2(SUM_BITS + 1);
  localparam int OUT_BITS      = COUNT_BITS + TIME_BITS + RATE_BITS;
  localparam int OUT_BYTES     = (OUT_BITS + 7) / 8;
  localparam int OUT_PAD       = OUT_BYTES * 8 - OUT_BITS;

  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(16);
  localparam logic [COUNT_BITS-1:0] WINDOW_TOP   = COUNT_BITS'(WIN_MAX);
  localparam logic [RATE_BITS-1:0]  RATE_SCALE   = RATE_BITS'(1000000000);

  // Request kinds carried in tuser
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [SUM_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                  valid;
    logic [COUNT_BITS-1:0] count;
    logic [TIME_BITS-1:0]  mean;
    logic [RATE_BITS-1:0]  rate;
  } result_t;

endpackage

// File: design/windowed_frame_rate_meter.sv
// Top level of the windowed frame rate meter: ports, output register and wiring.
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata timestamp_us, tuser req_type
// m_*       out  m_tvalid/m_tready   tdata filled_count, mean_interval_us, rate_millihertz
// cfg_*     in   cfg_we              cfg_data window_size
//
// A tick goes from its input beat through the ring and sum update (SUB, ADD), two passes
// (start, one step per quotient bit, done) through the one shared bit-serial divider
// (mean, then rate) and the output register load, which waits in DONE until the output
// is free. With a zero sum the rate pass is skipped. A restart goes straight to DONE.
// s_tready is high only while the sequencer is idle and no window write is present.
// The result sits in an output register, so the next beat is taken while it waits.
// rst is synchronous; the ring contents are not cleared and need no sweep.
module windowed_frame_rate_meter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [frm_pkg::TIME_BITS-1:0]      s_tdata,  // [31:0] timestamp_us
  input  logic [0:0]                         s_tuser,  // [0] req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [6:0] filled_count, [38:7] mean_interval_us, [68:39] rate_millihertz, rest zero
  output logic [frm_pkg::OUT_BYTES*8-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [frm_pkg::COUNT_BITS-1:0]     cfg_data
);
  import frm_pkg::*;

  logic      out_free;
  result_t   result;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign out_free = !m_tvalid || m_tready;

  frm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_req   (s_tuser[0]),
    .in_time  (s_tdata),
    .out_free (out_free),
    .result   (result),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  frm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register: load a finished result, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      m_tdata <= {{OUT_PAD{1'b0}}, result.rate, result.mean, result.count};
    end
  end

endmodule

// File: design/frm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module frm_div (
  input  logic              clk,
  input  logic              rst,
  input  frm_pkg::div_req_t req,
  output frm_pkg::div_rsp_t rsp
);
  import frm_pkg::*;

  logic                 busy;
  logic                 done;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]  divisor;
  logic [SUM_BITS-1:0]  quo;
  logic [SUM_BITS-1:0]  rem;
  logic [SUM_BITS:0]    rem_shift;
  logic [SUM_BITS+1:0]  diff;
  logic                 take;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_shift = {rem, quo[SUM_BITS-1]};
    diff      = {1'b0, rem_shift} - {2'b00, divisor};
    take      = !diff[SUM_BITS+1];
  end

  // Control: busy for SUM_BITS steps, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_BITS'(SUM_BITS);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= take ? diff[SUM_BITS-1:0] : rem_shift[SUM_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef NO_ASSERTIONS
  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");
`endif

endmodule

// File: design/frm_ctrl.sv
// Sequencer, interval ring and window state of the frame rate meter.
module frm_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [frm_pkg::COUNT_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req,
  input  logic [frm_pkg::TIME_BITS-1:0]  in_time,
  input  logic                           out_free,
  output frm_pkg::result_t               result,
  output frm_pkg::div_req_t              div_req,
  input  frm_pkg::div_rsp_t              div_rsp
);
  import frm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_SUB       = 8'b0000_0010,
    ST_ADD       = 8'b0000_0100,
    ST_MEAN_GO   = 8'b0000_1000,
    ST_MEAN_WAIT = 8'b0001_0000,
    ST_RATE_GO   = 8'b0010_0000,
    ST_RATE_WAIT = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [COUNT_BITS-1:0] window_size;
  logic [COUNT_BITS-1:0] win_eff;
  logic [SLOT_BITS-1:0]  write_slot;
  logic [COUNT_BITS-1:0] held_count;
  logic [SUM_BITS-1:0]   window_sum;
  logic [TIME_BITS-1:0]  previous_time;

  logic [TIME_BITS-1:0]  ring [WIN_MAX];
  logic [TIME_BITS-1:0]  rd_data;

  logic [SLOT_BITS-1:0]  slot_sel;
  logic [SLOT_BITS-1:0]  slot;
  logic                  full;
  logic [TIME_BITS-1:0]  interval;
  logic [SUM_BITS-1:0]   scaled;
  logic [TIME_BITS-1:0]  mean;
  logic [RATE_BITS-1:0]  rate;
  logic [COUNT_BITS:0]   slot_inc;
  logic                  accept;

  // Clamp the window to 1..WIN_MAX
  always_comb begin
    if (window_size == '0) begin
      win_eff = COUNT_BITS'(1);
    end else if (window_size > WINDOW_TOP) begin
      win_eff = WINDOW_TOP;
    end else begin
      win_eff = window_size;
    end
  end

  // Hold off input beats in the cycle of a window write
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !cfg_we;
  assign slot_sel = ({1'b0, write_slot} < win_eff) ? write_slot : '0;
  assign slot_inc = {2'b00, slot} + (COUNT_BITS + 1)'(1);

  // Ring: read the oldest slot at accept, overwrite it once the sum drops it
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ring[slot_sel];
    end
    if (state == ST_SUB) begin
      ring[slot] <= interval;
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (accept) begin
      slot     <= slot_sel;
      full     <= (held_count >= win_eff);
      interval <= in_time - previous_time;
    end
    if (state == ST_MEAN_GO) begin
      scaled <= SUM_BITS'(RATE_SCALE) * SUM_BITS'(held_count);
    end
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_size   <= WINDOW_RESET;
      write_slot    <= '0;
      held_count    <= '0;
      window_sum    <= '0;
      previous_time <= '0;
      mean          <= '0;
      rate          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          // apply a window write, or take the next beat
          if (cfg_we) begin
            window_size <= cfg_data;
            write_slot  <= '0;
            held_count  <= '0;
            window_sum  <= '0;
          end else if (accept) begin
            previous_time <= in_time;
            if (in_req == REQ_RESTART) begin
              write_slot <= '0;
              held_count <= '0;
              window_sum <= '0;
              mean       <= '0;
              rate       <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_SUB;
            end
          end
        end
        ST_SUB: begin
          // drop the overwritten interval once the window is full
          if (full) begin
            window_sum <= window_sum - SUM_BITS'(rd_data);
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          window_sum <= window_sum + SUM_BITS'(interval);
          write_slot <= (slot_inc >= {1'b0, win_eff}) ? '0 : slot_inc[SLOT_BITS-1:0];
          if (held_count < win_eff) begin
            held_count <= held_count + 1'b1;
          end
          state <= ST_MEAN_GO;
        end
        ST_MEAN_GO: begin
          state <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean <= div_rsp.quotient[TIME_BITS-1:0];
            if (window_sum == '0) begin
              rate  <= '0;
              state <= ST_DONE;
            end else begin
              state <= ST_RATE_GO;
            end
          end
        end
        ST_RATE_GO: begin
          state <= ST_RATE_WAIT;
        end
        ST_RATE_WAIT: begin
          if (div_rsp.done) begin
            // saturate when zero-length intervals push the rate over scale
            if (div_rsp.quotient > SUM_BITS'(RATE_SCALE)) begin
              rate <= RATE_SCALE;
            end else begin
              rate <= div_rsp.quotient[RATE_BITS-1:0];
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider requests: mean = sum / count, rate = scale * count / sum
  always_comb begin
    div_req.start    = (state == ST_MEAN_GO) || (state == ST_RATE_GO);
    div_req.dividend = window_sum;
    div_req.divisor  = SUM_BITS'(held_count);
    if (state == ST_RATE_GO) begin
      div_req.dividend = scaled;
      div_req.divisor  = window_sum;
    end
  end

  assign result.valid = (state == ST_DONE) && out_free;
  assign result.count = held_count;
  assign result.mean  = mean;
  assign result.rate  = rate;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.divisor != '0))
    else $error("division started with zero divisor");

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    held_count <= win_eff)
    else $error("held count exceeds window");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_req == REQ_RESTART)) |=> (held_count == '0) && (window_sum == '0))
    else $error("restart did not clear the window");
`endif

endmodule
